@@ hdl/fpdot_pkg.sv @@
`timescale 1ns / 1ps
package fpdot_pkg;

    // Queue word between front and back
    typedef struct packed {
        logic [31:0] prod;
        logic        last;
    } fpdot_word_t;

    localparam logic [31:0] QNAN = 32'h7FC00000;

    // Widen binary16 to binary32 exactly
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [31:0] r;
        logic [3:0]  lz;
        logic [9:0]  sm;
        begin
            e  = h[14:10];
            m  = h[9:0];
            r  = {h[15], 31'd0};
            lz = 4'd0;
            sm = m;
            if (e == 5'd31)
            begin
                r = {h[15], 8'hFF, m, 13'd0};
            end
            else if (e != 5'd0)
            begin
                r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
            end
            else if (m != 10'd0)
            begin
                for (int i = 0; i < 10; i++)
                begin
                    if (!sm[9])
                    begin
                        sm = sm << 1;
                        lz = lz + 4'd1;
                    end
                end
                // value m*2^-24: leading one at bit 9-lz -> exponent -15-lz
                r = {h[15], 8'd112 - {4'd0, lz}, sm[8:0], 14'd0};
            end
            widen_half = r;
        end
    endfunction

    // Exact binary32 product of two widened halves (product fits binary32)
    function automatic logic [31:0] mul_half(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] wa;
        logic [31:0] wb;
        logic        s;
        logic        na;
        logic        nb;
        logic        ia;
        logic        ib;
        logic        za;
        logic        zb;
        logic [47:0] p;
        logic signed [9:0] ex;
        logic [31:0] r;
        begin
            wa = widen_half(a);
            wb = widen_half(b);
            s  = wa[31] ^ wb[31];
            na = (wa[30:23] == 8'hFF) && (wa[22:0] != 23'd0);
            nb = (wb[30:23] == 8'hFF) && (wb[22:0] != 23'd0);
            ia = (wa[30:23] == 8'hFF) && !na;
            ib = (wb[30:23] == 8'hFF) && !nb;
            za = (wa[30:0] == 31'd0);
            zb = (wb[30:0] == 31'd0);
            p  = {1'b1, wa[22:0]} * {1'b1, wb[22:0]};
            ex = $signed({2'b0, wa[30:23]}) + $signed({2'b0, wb[30:23]}) - 10'sd127;
            if (na || nb || (ia && zb) || (ib && za))
            begin
                r = QNAN;
            end
            else if (ia || ib)
            begin
                r = {s, 8'hFF, 23'd0};
            end
            else if (za || zb)
            begin
                r = {s, 31'd0};
            end
            else
            begin
                if (p[47])
                begin
                    r = {s, ex[7:0] + 8'd1, p[46:24]};
                end
                else
                begin
                    r = {s, ex[7:0], p[45:23]};
                end
            end
            mul_half = r;
        end
    endfunction

endpackage

@@ hdl/fpdot_if.sv @@
`timescale 1ns / 1ps
interface fpdot_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_half;
    logic [15:0] right_half;
    logic        last_element;
    modport source (output valid, left_half, right_half, last_element, input ready);
    modport sink (input valid, left_half, right_half, last_element, output ready);
endinterface

interface fpdot_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] dot_value;
    modport source (output valid, dot_value, input ready);
    modport sink (input valid, dot_value, output ready);
endinterface

@@ hdl/fp16_dot_product_fp32_accumulate.sv @@
`timescale 1ns / 1ps
// channel   dir  fields                                  handshake
// in_ch     in   left_half, right_half, last_element     valid/ready
// out_ch    out  dot_value                               valid/ready
// cfg       in   negate_result (cfg_data[0])             cfg_we
//
// Each word passes through the shared two-stage adder before the next is taken.
// A last word adds a reduction that passes every lane through the adder.
// Reset clears lanes through valid bits; no clearing sweep.
// A four-deep queue lets the front take words while the back is busy.
module fp16_dot_product_fp32_accumulate
    import fpdot_pkg::*;
#(
    parameter int LANES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    fpdot_in_if.sink    in_ch,
    fpdot_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_data
);
    logic        neg_reg;
    logic        q_valid;
    logic        q_pop;
    fpdot_word_t q_word;

    // hold negate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            neg_reg <= cfg_data[0];
        end
    end

    fpdot_front #(.DEPTH(4)) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_word  (q_word)
    );

    fpdot_back #(.LANES(LANES)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .negate  (neg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_word  (q_word),
        .out_ch  (out_ch)
    );
endmodule

@@ hdl/fpdot_add.sv @@
`timescale 1ns / 1ps
// binary32 adder, round to nearest even, two register stages
module fpdot_add
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] sum
);
    localparam logic [31:0] QNAN_LOCAL = 32'h7FC00000;

    // stage 1 registers, then stage 2 valid and sum
    logic        v1_reg;
    logic        special_reg;
    logic [31:0] special_val_reg;
    logic        s_reg;
    logic [8:0]  e_reg;
    logic [27:0] mag_reg;
    logic        v2_reg;
    logic [31:0] sum_reg;

    logic        na;
    logic        nb;
    logic        ia;
    logic        ib;
    logic [31:0] big;
    logic [31:0] lit;
    logic [7:0]  eb;
    logic [7:0]  el;
    logic [26:0] mb;
    logic [26:0] ml;
    logic [7:0]  d;
    logic [26:0] sh;
    logic        stk;
    logic [27:0] m;
    logic        sp;
    logic [31:0] spv;

    // align and add
    always_comb
    begin
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && !na;
        ib = (b[30:23] == 8'hFF) && !nb;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            lit = b;
        end
        else
        begin
            big = b;
            lit = a;
        end
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        el  = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
        mb  = {big[30:23] != 8'd0, big[22:0], 3'd0};
        ml  = {lit[30:23] != 8'd0, lit[22:0], 3'd0};
        d   = eb - el;
        if (d > 8'd26)
        begin
            sh  = 27'd0;
            stk = (ml != 27'd0);
        end
        else
        begin
            sh  = ml >> d;
            stk = ((sh << d) != ml);
        end
        sh[0] = sh[0] | stk;
        if (big[31] == lit[31])
        begin
            m = {1'b0, mb} + {1'b0, sh};
        end
        else
        begin
            m = {1'b0, mb} - {1'b0, sh};
        end
        sp  = 1'b0;
        spv = QNAN_LOCAL;
        if (na || nb || (ia && ib && (a[31] != b[31])))
        begin
            sp  = 1'b1;
            spv = QNAN_LOCAL;
        end
        else if (ia || ib)
        begin
            sp  = 1'b1;
            spv = ia ? a : b;
        end
        else if (m == 28'd0)
        begin
            sp  = 1'b1;
            spv = {a[31] & b[31], 31'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        special_reg     <= sp;
        special_val_reg <= spv;
        s_reg           <= big[31];
        e_reg           <= {1'b0, eb};
        mag_reg         <= m;
    end

    // normalise and round
    logic [4:0]  lz;
    logic [27:0] nm;
    logic [9:0]  ne;
    logic [27:0] t;
    logic [31:0] res;
    logic        rs;
    logic        rnd;
    logic [24:0] mr;

    always_comb
    begin
        // highest set bit wins
        lz = 5'd0;
        t  = mag_reg;
        for (int i = 0; i <= 26; i++)
        begin
            if (mag_reg[i])
            begin
                lz = 5'(26 - i);
            end
        end
        if (mag_reg[27])
        begin
            nm = {1'b0, mag_reg[27:2], mag_reg[1] | mag_reg[0]};
            ne = {1'b0, e_reg} + 10'd1;
        end
        else
        begin
            // limit shift so exponent stays at least 1
            if ({5'd0, lz} >= {1'b0, e_reg})
            begin
                t  = mag_reg << (e_reg[7:0] - 8'd1);
                ne = 10'd0;
            end
            else
            begin
                t  = mag_reg << lz;
                ne = {1'b0, e_reg} - {5'd0, lz};
            end
            nm = t;
        end
        rnd = nm[2] && (nm[1] || nm[0] || nm[3]);
        mr  = {1'b0, nm[26:3]} + {24'd0, rnd};
        rs  = s_reg;
        if (ne == 10'd0)
        begin
            res = {rs, (mr[23] ? 8'd1 : 8'd0), mr[22:0]};
        end
        else if (mr[24])
        begin
            res = {rs, ne[7:0] + 8'd1, mr[23:1]};
        end
        else
        begin
            res = {rs, ne[7:0], mr[22:0]};
        end
        if ((ne != 10'd0) && ((ne + {9'd0, mr[24]}) >= 10'd255))
        begin
            res = {rs, 8'hFF, 23'd0};
        end
        if (special_reg)
        begin
            res = special_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= res;
    end

    assign done = v2_reg;
    assign sum  = sum_reg;
endmodule

@@ hdl/fpdot_front.sv @@
`timescale 1ns / 1ps
// accept pairs, form exact products, push to queue
module fpdot_front
    import fpdot_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    fpdot_in_if.sink      in_ch,
    output logic          q_valid,
    input  logic          q_pop,
    output fpdot_word_t   q_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    fpdot_word_t      mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push;

    assign in_ch.ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_word      = mem_reg[rp_reg];

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{prod: mul_half(in_ch.left_half, in_ch.right_half),
                                 last: in_ch.last_element};
        end
    end
endmodule

@@ hdl/fpdot_back.sv @@
`timescale 1ns / 1ps
// accumulate into lanes, reduce on last word
module fpdot_back
    import fpdot_pkg::*;
#(
    parameter int LANES = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          negate,
    input  logic          q_valid,
    output logic          q_pop,
    input  fpdot_word_t   q_word,
    fpdot_out_if.source   out_ch
);
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_REDW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [31:0]   lane_reg [LANES];
    logic [LANES-1:0] lv_reg;
    logic [LW-1:0] ptr_reg;
    logic [LW-1:0] ri_reg;
    logic [2:0]    st_reg;
    logic          last_reg;
    logic [31:0]   tot_reg;
    logic [31:0]   out_reg;
    logic          ov_reg;

    logic          a_start;
    logic [31:0]   a_a;
    logic [31:0]   a_b;
    logic          a_done;
    logic [31:0]   a_sum;
    logic [31:0]   lane_val;
    logic [31:0]   red_val;
    logic          out_load;

    assign lane_val = lv_reg[ptr_reg] ? lane_reg[ptr_reg] : 32'd0;
    assign red_val  = lv_reg[ri_reg] ? lane_reg[ri_reg] : 32'd0;
    assign q_pop    = (st_reg == S_IDLE) && q_valid;
    assign a_start  = q_pop || (st_reg == S_RED);
    assign a_a      = (st_reg == S_RED) ? tot_reg : lane_val;
    assign a_b      = (st_reg == S_RED) ? red_val : q_word.prod;
    assign out_load = (st_reg == S_OUT) && (!ov_reg || out_ch.ready);

    fpdot_add u_add
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (a_start),
        .a     (a_a),
        .b     (a_b),
        .done  (a_done),
        .sum   (a_sum)
    );

    assign out_ch.valid     = ov_reg;
    assign out_ch.dot_value = out_reg;

    // sequence accumulation and reduction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ptr_reg  <= '0;
            ri_reg   <= '0;
            lv_reg   <= '0;
            last_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready && (st_reg != S_OUT))
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        last_reg <= q_word.last;
                        st_reg   <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (a_done)
                    begin
                        lv_reg[ptr_reg] <= 1'b1;
                        ptr_reg <= (ptr_reg == LW'(LANES - 1)) ? '0 : ptr_reg + 1'b1;
                        ri_reg  <= '0;
                        st_reg  <= last_reg ? S_RED : S_IDLE;
                    end
                end
                S_RED:
                begin
                    st_reg <= S_REDW;
                end
                S_REDW:
                begin
                    if (a_done)
                    begin
                        if (ri_reg == LW'(LANES - 1))
                        begin
                            st_reg <= S_OUT;
                        end
                        else
                        begin
                            ri_reg <= ri_reg + 1'b1;
                            st_reg <= S_RED;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        ov_reg  <= 1'b1;
                        lv_reg  <= '0;
                        ptr_reg <= '0;
                        st_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    // hold lane and running totals
    always_ff @(posedge clk)
    begin
        if ((st_reg == S_ACC) && a_done)
        begin
            lane_reg[ptr_reg] <= a_sum;
            tot_reg <= 32'd0;
        end
        if ((st_reg == S_REDW) && a_done)
        begin
            tot_reg <= a_sum;
        end
        if (out_load)
        begin
            out_reg <= (((tot_reg[30:23] == 8'hFF) && (tot_reg[22:0] != 23'd0)) ? QNAN
                        : tot_reg) ^ {negate, 31'd0};
        end
    end
endmodule
